/* src/fat_block_allocator_top_defines.svh */
// assertion macros for the block allocator
`ifndef FAT_BLOCK_ALLOCATOR_TOP_DEFINES_SVH
`define FAT_BLOCK_ALLOCATOR_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
// checked only while out of reset
`define FBA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// checked at every edge, reset included
`define FBA_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define FBA_ASSERT(lbl, prop, msg)
`define FBA_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

/* src/fba_pkg.sv */
`default_nettype none
package fba_pkg;

    // table geometry
    localparam int NUM_BLOCKS = 256;
    localparam int TABLE_SIZE = (NUM_BLOCKS < 256) ? NUM_BLOCKS : 256;
    localparam int IDX_W      = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
    localparam int CNT_W      = $clog2(TABLE_SIZE + 1);

    // field widths
    localparam int ACT_W   = 2;
    localparam int BLOCK_W = 8;
    localparam int VAL_W   = 9;
    localparam int ST_W    = 2;
    localparam int FREED_W = 9;

    // entry codes
    localparam logic signed [VAL_W-1:0] VAL_END  = -9'sd1;
    localparam logic signed [VAL_W-1:0] VAL_FREE = 9'sd0;

    typedef enum logic [ACT_W-1:0] {
        ACT_ALLOC = 2'd0,
        ACT_FREE  = 2'd1,
        ACT_READ  = 2'd2,
        ACT_WRITE = 2'd3
    } t_action;

    typedef enum logic [ST_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2,
        ST_LOOP  = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_FREE_CHK,
        S_FREE_WR,
        S_READ,
        S_READ_WAIT,
        S_WRITE,
        S_DONE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic    load;
        logic    clr;
        logic    scan;
        logic    alloc_hit;
        logic    alloc_full;
        logic    fr_read;
        logic    fr_clear;
        logic    rd_issue;
        logic    rd_take;
        logic    wr_do;
        logic    set_st;
        t_status st_code;
        logic    out_load;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic clr_last;
        logic found;
        logic full;
        logic cur_end;
        logic cur_bad;
        logic loop_hit;
        logic blk_bad;
        logic out_free;
    } t_dp_sts;

endpackage
`default_nettype wire

/* src/fba_dp.sv */
`default_nettype none
module fba_dp
    import fba_pkg::*;
(
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic [BLOCK_W-1:0]        i_block,
    input  wire logic signed [VAL_W-1:0]   i_entry_value,
    input  wire logic                      i_ready,
    input  wire t_dp_cmd                   i_cmd,
    output t_dp_sts                        o_sts,
    output logic                           o_valid,
    output logic [ST_W-1:0]                o_status,
    output logic signed [VAL_W-1:0]        o_result_value,
    output logic [FREED_W-1:0]             o_freed_count
);

    // allocation table
    logic signed [VAL_W-1:0] mem [TABLE_SIZE];

    logic [BLOCK_W-1:0]      r_block;
    logic signed [VAL_W-1:0] r_wval;
    logic signed [VAL_W-1:0] r_cur;
    logic [CNT_W-1:0]        r_freed;
    logic [IDX_W:0]          r_idx;
    logic [IDX_W-1:0]        r_rd_idx;
    logic                    r_rd_vld;
    logic signed [VAL_W-1:0] r_rdata;
    t_status                 r_status;
    logic signed [VAL_W-1:0] r_result;
    logic                    r_o_valid;
    t_status                 r_o_status;
    logic signed [VAL_W-1:0] r_o_result;
    logic [CNT_W-1:0]        r_o_freed;

    logic                    we;
    logic [IDX_W-1:0]        waddr;
    logic signed [VAL_W-1:0] wdata;
    logic                    re;
    logic [IDX_W-1:0]        raddr;
    logic                    scan_issue;
    logic [IDX_W-1:0]        cur_idx;
    logic [IDX_W-1:0]        blk_idx;

    assign cur_idx    = r_cur[IDX_W-1:0];
    assign blk_idx    = r_block[IDX_W-1:0];
    assign scan_issue = i_cmd.scan && (r_idx < (IDX_W+1)'(TABLE_SIZE));

    // write port select
    always_comb begin
        we    = 1'b1;
        waddr = r_idx[IDX_W-1:0];
        wdata = VAL_FREE;
        if (i_cmd.clr) begin
            waddr = r_idx[IDX_W-1:0];
            wdata = VAL_FREE;
        end else if (i_cmd.alloc_hit) begin
            waddr = r_rd_idx;
            wdata = VAL_END;
        end else if (i_cmd.fr_clear) begin
            waddr = cur_idx;
            wdata = VAL_FREE;
        end else if (i_cmd.wr_do) begin
            waddr = blk_idx;
            wdata = r_wval;
        end else begin
            we = 1'b0;
        end
    end

    // read port select
    always_comb begin
        re    = 1'b1;
        raddr = r_idx[IDX_W-1:0];
        if (scan_issue) begin
            raddr = r_idx[IDX_W-1:0];
        end else if (i_cmd.fr_read) begin
            raddr = cur_idx;
        end else if (i_cmd.rd_issue) begin
            raddr = blk_idx;
        end else begin
            re = 1'b0;
        end
    end

    // table memory, registered read
    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            r_rdata <= mem[raddr];
        end
    end

    // item registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx     <= '0;
            r_rd_vld  <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_block  <= i_block;
                r_wval   <= i_entry_value;
                r_cur    <= $signed({1'b0, i_block});
                r_freed  <= '0;
                r_idx    <= '0;
                r_rd_vld <= 1'b0;
                r_status <= ST_OK;
                r_result <= VAL_FREE;
            end
            if (i_cmd.clr) begin
                r_idx <= r_idx + 1'b1;
            end
            if (i_cmd.scan) begin
                r_rd_vld <= scan_issue;
                r_rd_idx <= r_idx[IDX_W-1:0];
                if (scan_issue) begin
                    r_idx <= r_idx + 1'b1;
                end
            end
            if (i_cmd.alloc_hit) begin
                r_status <= ST_OK;
                r_result <= $signed({{(VAL_W-IDX_W){1'b0}}, r_rd_idx});
            end
            if (i_cmd.alloc_full) begin
                r_status <= ST_FULL;
                r_result <= VAL_END;
            end
            if (i_cmd.fr_clear) begin
                r_freed <= r_freed + 1'b1;
                r_cur   <= r_rdata;
            end
            if (i_cmd.rd_take) begin
                r_result <= r_rdata;
            end
            if (i_cmd.set_st) begin
                r_status <= i_cmd.st_code;
            end
            // output word register
            if (i_cmd.out_load) begin
                r_o_valid  <= 1'b1;
                r_o_status <= r_status;
                r_o_result <= r_result;
                r_o_freed  <= r_freed;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // status to the controller
    always_comb begin
        o_sts.clr_last = (r_idx[IDX_W-1:0] == IDX_W'(TABLE_SIZE - 1));
        o_sts.found    = r_rd_vld && (r_rdata == VAL_FREE);
        o_sts.full     = r_rd_vld && (r_rdata != VAL_FREE)
                         && (r_rd_idx == IDX_W'(TABLE_SIZE - 1));
        o_sts.cur_end  = (r_cur == VAL_END);
        o_sts.cur_bad  = r_cur[VAL_W-1] || ($unsigned(r_cur) >= VAL_W'(TABLE_SIZE));
        o_sts.loop_hit = (r_freed >= CNT_W'(TABLE_SIZE));
        o_sts.blk_bad  = ({1'b0, r_block} >= (BLOCK_W+1)'(TABLE_SIZE));
        o_sts.out_free = !r_o_valid || i_ready;
    end

    assign o_valid        = r_o_valid;
    assign o_status       = r_o_status;
    assign o_result_value = r_o_result;
    assign o_freed_count  = FREED_W'(r_o_freed);

endmodule
`default_nettype wire

/* src/fba_ctrl.sv */
`default_nettype none
module fba_ctrl
    import fba_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire logic [ACT_W-1:0]  i_action,
    input  wire t_dp_sts           i_sts,
    output logic                   o_ready,
    output t_dp_cmd                o_cmd
);

    t_state r_state;
    t_state n_state;

    // state register, clearing pass after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state       = r_state;
        o_cmd         = '0;
        o_cmd.st_code = ST_OK;
        o_ready       = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    case (t_action'(i_action))
                        ACT_ALLOC: n_state = S_SCAN;
                        ACT_FREE:  n_state = S_FREE_CHK;
                        ACT_READ:  n_state = S_READ;
                        ACT_WRITE: n_state = S_WRITE;
                        default:   n_state = S_IDLE;
                    endcase
                end
            end
            // first-fit scan, one entry read per cycle
            S_SCAN: begin
                if (i_sts.found) begin
                    o_cmd.alloc_hit = 1'b1;
                    n_state = S_DONE;
                end else if (i_sts.full) begin
                    o_cmd.alloc_full = 1'b1;
                    n_state = S_DONE;
                end else begin
                    o_cmd.scan = 1'b1;
                end
            end
            // chain walk: check pointer, then read and clear
            S_FREE_CHK: begin
                if (i_sts.cur_end) begin
                    n_state = S_DONE;
                end else if (i_sts.cur_bad) begin
                    o_cmd.set_st  = 1'b1;
                    o_cmd.st_code = ST_RANGE;
                    n_state = S_DONE;
                end else if (i_sts.loop_hit) begin
                    o_cmd.set_st  = 1'b1;
                    o_cmd.st_code = ST_LOOP;
                    n_state = S_DONE;
                end else begin
                    o_cmd.fr_read = 1'b1;
                    n_state = S_FREE_WR;
                end
            end
            S_FREE_WR: begin
                o_cmd.fr_clear = 1'b1;
                n_state = S_FREE_CHK;
            end
            S_READ: begin
                if (i_sts.blk_bad) begin
                    o_cmd.set_st  = 1'b1;
                    o_cmd.st_code = ST_RANGE;
                    n_state = S_DONE;
                end else begin
                    o_cmd.rd_issue = 1'b1;
                    n_state = S_READ_WAIT;
                end
            end
            S_READ_WAIT: begin
                o_cmd.rd_take = 1'b1;
                n_state = S_DONE;
            end
            S_WRITE: begin
                if (i_sts.blk_bad) begin
                    o_cmd.set_st  = 1'b1;
                    o_cmd.st_code = ST_RANGE;
                end else begin
                    o_cmd.wr_do = 1'b1;
                end
                n_state = S_DONE;
            end
            // hand the word to the output register once it is free
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

/* src/fat_block_allocator_top.sv */
// allocate: first-fit scan reading one entry per cycle, up to the whole table; free: chain
// walk that reads then clears each entry in turn; read and write access the entry at i_block;
// one item is in work at a time, the next is taken while the previous word waits in the
// output register
// reset: synchronous active low, then a pass clearing all TABLE_SIZE (256) entries, o_ready low
`default_nettype none
`include "fat_block_allocator_top_defines.svh"
module fat_block_allocator_top
    import fba_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_valid,
    output logic                          o_ready,
    input  wire logic [ACT_W-1:0]         i_action,
    input  wire logic [BLOCK_W-1:0]       i_block,
    input  wire logic signed [VAL_W-1:0]  i_entry_value,
    output logic                          o_valid,
    input  wire logic                     i_ready,
    output logic [ST_W-1:0]               o_status,
    output logic signed [VAL_W-1:0]       o_result_value,
    output logic [FREED_W-1:0]            o_freed_count
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    // sequencer
    fba_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_action (i_action),
        .i_sts    (sts),
        .o_ready  (o_ready),
        .o_cmd    (cmd)
    );

    // table and item datapath
    fba_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_block        (i_block),
        .i_entry_value  (i_entry_value),
        .i_ready        (i_ready),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .o_valid        (o_valid),
        .o_status       (o_status),
        .o_result_value (o_result_value),
        .o_freed_count  (o_freed_count)
    );

    // result word consistency
    `FBA_ASSERT(a_full_gives_end, (o_valid && o_status == ST_FULL) |-> (o_result_value == VAL_END), "full table must return end mark")
    `FBA_ASSERT(a_loop_count, (o_valid && o_status == ST_LOOP) |-> (o_freed_count == FREED_W'(TABLE_SIZE)), "loop stop must report a full count")
    `FBA_ASSERT(a_freed_bound, o_valid |-> (o_freed_count <= FREED_W'(TABLE_SIZE)), "freed count above table size")
    `FBA_ASSERT_ALWAYS(a_no_ready_in_reset, !i_rst_n |=> !o_ready, "input taken during clearing pass")

endmodule
`default_nettype wire
